@@ src/cte_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package cte_pkg;
  localparam int CAL_SAMPLES = 5000;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W = $clog2(CORDIC_STEPS + 1);
  localparam int CNT_W = 13;
  localparam logic signed [24:0] ANGLE_LIMIT = 25'sd11796480;
  localparam logic signed [24:0] RIGHT_ANGLE = 25'sd5898240;
  localparam logic [16:0] WEIGHT_ONE = 17'd65536;

  // offset mean: exact floor division by CAL_SAMPLES of a 30-bit value by reciprocal
  localparam int MEAN_K = 30 + $clog2(CAL_SAMPLES);
  localparam logic [31:0] MEAN_RECIP =
    32'(((64'd1 << MEAN_K) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
  localparam logic [29:0] MEAN_DIV = 30'(CAL_SAMPLES);
  localparam logic [29:0] MEAN_HALF = 30'(CAL_SAMPLES / 2);

  typedef enum logic [0:0] {
    REQ_CAL = 1'b0,
    REQ_EST = 1'b1
  } req_t;

  typedef enum logic [0:0] {
    CFG_GYRO_GAIN = 1'b0,
    CFG_ACCEL_WEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_CORDIC,
    ST_MEAN,
    ST_FUSE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic done;
  } lane_ctl_t;

  function automatic logic signed [24:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0: atan_lut = 25'sd2949120;
      5'd1: atan_lut = 25'sd1740967;
      5'd2: atan_lut = 25'sd919879;
      5'd3: atan_lut = 25'sd466945;
      5'd4: atan_lut = 25'sd234379;
      5'd5: atan_lut = 25'sd117304;
      5'd6: atan_lut = 25'sd58666;
      5'd7: atan_lut = 25'sd29335;
      5'd8: atan_lut = 25'sd14668;
      5'd9: atan_lut = 25'sd7334;
      5'd10: atan_lut = 25'sd3667;
      5'd11: atan_lut = 25'sd1833;
      5'd12: atan_lut = 25'sd917;
      5'd13: atan_lut = 25'sd458;
      5'd14: atan_lut = 25'sd229;
      5'd15: atan_lut = 25'sd115;
      5'd16: atan_lut = 25'sd57;
      5'd17: atan_lut = 25'sd29;
      5'd18: atan_lut = 25'sd14;
      5'd19: atan_lut = 25'sd7;
      5'd20: atan_lut = 25'sd4;
      5'd21: atan_lut = 25'sd2;
      5'd22: atan_lut = 25'sd1;
      default: atan_lut = 25'sd0;
    endcase
  endfunction
endpackage
`default_nettype wire

@@ src/complementary_tilt_estimator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Roll/pitch complementary filter with gyro offset calibration. One word is
// worked on at a time: in_stall stays high from acceptance until the result
// word has been taken. A calibration word passes through ST_OUT to its
// result; the word that closes calibration first passes through ST_MEAN,
// where the two offset means are formed by reciprocal multiplication: a
// first quotient, the scaled remainder, a second quotient, the signed bias.
// An estimate word runs two lanes side by side, each a bit-serial root then
// CORDIC_STEPS vectoring steps, followed by a four-stage blend; when both
// root axes of both lanes are zero the lanes skip root and CORDIC steps.
// The next word is taken only after the result word has been taken, so
// output stalls hold off the next word.
module complementary_tilt_estimator
  import cte_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_req_type,
  input  wire logic signed [15:0] in_accel_x,
  input  wire logic signed [15:0] in_accel_y,
  input  wire logic signed [15:0] in_accel_z,
  input  wire logic signed [15:0] in_gyro_x,
  input  wire logic signed [15:0] in_gyro_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [24:0]      out_roll_angle,
  output logic signed [24:0]      out_pitch_angle,
  output logic                    out_calibration_done,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [23:0]        cfg_data
);
  state_t st_r, st_nxt;
  logic [23:0] gain_r;
  logic [16:0] weight_r;
  logic signed [24:0] roll_r, pitch_r;
  logic signed [31:0] bias_x_r, bias_y_r;
  logic signed [29:0] sum_x_r, sum_y_r;
  logic [CNT_W-1:0] cnt_r;
  logic signed [15:0] gx_r, gy_r;
  logic signed [24:0] acc_r_r, acc_p_r;
  logic done_r, ov_r;
  logic [1:0] lane_got_r;
  lane_ctl_t lctl;
  logic ld0, ld1, md0, md1;
  logic signed [24:0] la0, la1, fa0, fa1;
  logic acc_in, acc_out;
  logic signed [29:0] nsx, nsy;
  logic [CNT_W-1:0] ncnt;
  logic signed [16:0] pnum;
  logic mstart;

  // offset mean: s = |sum|, q = (s / N) << 16 + ((s % N) << 16 + N/2) / N
  logic [29:0] mag_x_r, mag_y_r, qa_x_r, qa_y_r, t_x_r, t_y_r, qb_x_r, qb_y_r;
  logic [1:0] mi_r;
  logic sx_r, sy_r;
  logic [29:0] nmag_x, nmag_y, rm_x, rm_y;
  logic [61:0] pa_x, pa_y, pb_x, pb_y;
  logic [31:0] q_x, q_y;

  assign acc_in = in_valid && !in_stall;
  assign acc_out = out_valid && !out_stall;
  assign in_stall = (st_r != ST_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_roll_angle = roll_r;
  assign out_pitch_angle = pitch_r;
  assign out_calibration_done = done_r;
  assign pnum = -17'(in_accel_x);
  assign nsx = sum_x_r + 30'(in_gyro_x);
  assign nsy = sum_y_r + 30'(in_gyro_y);
  assign ncnt = cnt_r + 1'b1;

  always_comb begin
    lctl.start = acc_in && (in_req_type == REQ_EST);
    lctl.done = lane_got_r[0] && lane_got_r[1];
  end

  cte_lane u_lr (.clk, .rst_n, .start(lctl.start), .num(17'(in_accel_y)),
    .a(in_accel_z), .b(in_accel_x), .done(ld0), .angle(la0));
  cte_lane u_lp (.clk, .rst_n, .start(lctl.start), .num(pnum),
    .a(in_accel_z), .b(in_accel_y), .done(ld1), .angle(la1));

  assign mstart = (st_r == ST_CORDIC) && lctl.done;
  cte_merge u_mr (.clk, .rst_n, .start(mstart), .prev(roll_r), .gyro(gx_r),
    .bias(bias_x_r), .acc(acc_r_r), .gain(gain_r), .weight(weight_r), .done(md0),
    .angle(fa0));
  cte_merge u_mp (.clk, .rst_n, .start(mstart), .prev(pitch_r), .gyro(gy_r),
    .bias(bias_y_r), .acc(acc_p_r), .gain(gain_r), .weight(weight_r), .done(md1),
    .angle(fa1));

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:
        if (acc_in) begin
          if (in_req_type == REQ_EST) st_nxt = ST_CORDIC;
          else if (ncnt >= CNT_W'(CAL_SAMPLES)) st_nxt = ST_MEAN;
          else st_nxt = ST_OUT;
        end
      ST_CORDIC: if (lctl.done) st_nxt = ST_FUSE;
      ST_FUSE: if (md0) st_nxt = ST_OUT;
      ST_MEAN: if (mi_r == 2'd3) st_nxt = ST_OUT;
      ST_OUT: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    nmag_x = $unsigned(nsx[29] ? -nsx : nsx);
    nmag_y = $unsigned(nsy[29] ? -nsy : nsy);
    pa_x = 62'(mag_x_r) * 62'(MEAN_RECIP);
    pa_y = 62'(mag_y_r) * 62'(MEAN_RECIP);
    pb_x = 62'(t_x_r) * 62'(MEAN_RECIP);
    pb_y = 62'(t_y_r) * 62'(MEAN_RECIP);
    rm_x = mag_x_r - qa_x_r * MEAN_DIV;
    rm_y = mag_y_r - qa_y_r * MEAN_DIV;
    q_x = 32'({qa_x_r, 16'd0}) + 32'(qb_x_r);
    q_y = 32'({qa_y_r, 16'd0}) + 32'(qb_y_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      gain_r <= 24'd4092;
      weight_r <= 17'd2621;
      roll_r <= '0;
      pitch_r <= '0;
      bias_x_r <= '0;
      bias_y_r <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      cnt_r <= '0;
      ov_r <= 1'b0;
      done_r <= 1'b0;
      lane_got_r <= '0;
      mi_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_GYRO_GAIN) gain_r <= cfg_data;
        else weight_r <= cfg_data[16:0];
      end
      if (acc_out) ov_r <= 1'b0;
      if (acc_in) begin
        gx_r <= in_gyro_x;
        gy_r <= in_gyro_y;
        done_r <= 1'b0;
        lane_got_r <= '0;
        if (in_req_type == REQ_CAL) begin
          if (ncnt >= CNT_W'(CAL_SAMPLES)) begin
            sx_r <= nsx[29];
            sy_r <= nsy[29];
            mag_x_r <= nmag_x;
            mag_y_r <= nmag_y;
            mi_r <= '0;
            sum_x_r <= '0;
            sum_y_r <= '0;
            cnt_r <= '0;
            done_r <= 1'b1;
          end else begin
            sum_x_r <= nsx;
            sum_y_r <= nsy;
            cnt_r <= ncnt;
          end
        end
      end
      if (ld0) begin acc_r_r <= la0; lane_got_r[0] <= 1'b1; end
      if (ld1) begin acc_p_r <= la1; lane_got_r[1] <= 1'b1; end
      if (st_r == ST_MEAN) begin
        mi_r <= mi_r + 2'd1;
        case (mi_r)
          2'd0: begin
            qa_x_r <= 30'(pa_x >> MEAN_K);
            qa_y_r <= 30'(pa_y >> MEAN_K);
          end
          2'd1: begin
            t_x_r <= (rm_x << 16) + MEAN_HALF;
            t_y_r <= (rm_y << 16) + MEAN_HALF;
          end
          2'd2: begin
            qb_x_r <= 30'(pb_x >> MEAN_K);
            qb_y_r <= 30'(pb_y >> MEAN_K);
          end
          default: begin
            bias_x_r <= sx_r ? -$signed(q_x) : $signed(q_x);
            bias_y_r <= sy_r ? -$signed(q_y) : $signed(q_y);
          end
        endcase
      end
      if (st_r == ST_FUSE && md0 && md1) begin
        roll_r <= fa0;
        pitch_r <= fa1;
      end
      if (st_r == ST_OUT) ov_r <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_roll_angle) && $stable(out_pitch_angle))
    else $error("result moved under stall");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("took word with result pending");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_W'(CAL_SAMPLES)) else $error("count overran");
`endif
endmodule
`default_nettype wire

@@ src/cte_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cte_lane
  import cte_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [16:0] num,
  input  wire logic signed [15:0] a,
  input  wire logic signed [15:0] b,
  output logic                    done,
  output logic signed [24:0]      angle
);
  // root: 33-bit radicand shifted by 16 -> 49 bits, 25-bit root, one bit per cycle
  typedef enum logic [1:0] {L_IDLE, L_SQRT, L_CORD, L_DONE} lst_t;
  lst_t st_r, st_nxt;
  logic [49:0] rem_r, rem_nxt;
  logic [49:0] rad_r, rad_nxt;
  logic [24:0] root_r, root_nxt;
  logic [4:0]  bit_r, bit_nxt;
  logic [STEP_W-1:0] it_r, it_nxt;
  logic signed [27:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [26:0] z_r, z_nxt;
  logic [1:0] sp_r, sp_nxt;
  logic signed [31:0] aa, bb;
  logic [32:0] sq;
  logic [51:0] trial;
  logic signed [27:0] xs, ys;

  always_comb begin
    aa = a * a;
    bb = b * b;
    sq = {1'b0, aa} + {1'b0, bb};
  end

  always_comb begin
    st_nxt = st_r;
    rem_nxt = rem_r;
    rad_nxt = rad_r;
    root_nxt = root_r;
    bit_nxt = bit_r;
    it_nxt = it_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    sp_nxt = sp_r;
    trial = '0;
    xs = x_r >>> it_r;
    ys = y_r >>> it_r;
    case (st_r)
      L_IDLE: begin
        if (start) begin
          z_nxt = '0;
          it_nxt = '0;
          y_nxt = 28'(num) <<< 8;
          if (sq == '0) begin
            sp_nxt = (num == 0) ? 2'd1 : 2'd2;
            st_nxt = L_DONE;
          end else begin
            sp_nxt = 2'd0;
            rad_nxt = {1'b0, sq, 16'd0};
            rem_nxt = '0;
            root_nxt = '0;
            bit_nxt = 5'd24;
            st_nxt = L_SQRT;
          end
        end
      end
      L_SQRT: begin
        trial = {rem_r, rad_r[49:48]} - {25'd0, root_r, 2'b01};
        if (!trial[51]) begin
          rem_nxt = trial[49:0];
          root_nxt = {root_r[23:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[47:0], rad_r[49:48]};
          root_nxt = {root_r[23:0], 1'b0};
        end
        rad_nxt = {rad_r[47:0], 2'b00};
        bit_nxt = bit_r - 5'd1;
        if (bit_r == '0) begin
          x_nxt = {3'b000, root_nxt};
          st_nxt = L_CORD;
        end
      end
      L_CORD: begin
        if (y_r > 0) begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + 27'(atan_lut(5'(it_r)));
        end else if (y_r < 0) begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - 27'(atan_lut(5'(it_r)));
        end
        it_nxt = it_r + 1'b1;
        if (it_r == STEP_W'(CORDIC_STEPS - 1)) st_nxt = L_DONE;
      end
      L_DONE: st_nxt = L_IDLE;
      default: st_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= L_IDLE;
    else st_r <= st_nxt;
    rem_r <= rem_nxt;
    rad_r <= rad_nxt;
    root_r <= root_nxt;
    bit_r <= bit_nxt;
    it_r <= it_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    sp_r <= sp_nxt;
  end

  always_comb begin
    done = (st_r == L_DONE);
    if (sp_r == 2'd1) angle = '0;
    else if (sp_r == 2'd2) angle = y_r[27] ? -RIGHT_ANGLE : RIGHT_ANGLE;
    else if (z_r > 27'(RIGHT_ANGLE)) angle = RIGHT_ANGLE;
    else if (z_r < -27'(RIGHT_ANGLE)) angle = -RIGHT_ANGLE;
    else angle = z_r[24:0];
  end
endmodule
`default_nettype wire

@@ src/cte_merge.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cte_merge
  import cte_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [24:0] prev,
  input  wire logic signed [15:0] gyro,
  input  wire logic signed [31:0] bias,
  input  wire logic signed [24:0] acc,
  input  wire logic [23:0]        gain,
  input  wire logic [16:0]        weight,
  output logic                    done,
  output logic signed [24:0]      angle
);
  // four registered steps: diff, split product, gyro angle, blend
  logic [3:0] v_r;
  logic signed [32:0] diff_r;
  logic signed [57:0] hi_r, lo_r;
  logic signed [34:0] g_r;
  logic signed [58:0] blend_r;
  logic [16:0] w;
  logic signed [57:0] prod;
  logic signed [42:0] rv;

  always_comb begin
    w = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
    prod = hi_r + lo_r;
    rv = 43'((blend_r + 59'sd32768) >>> 16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else v_r <= {v_r[2:0], start};
    diff_r <= (33'(gyro) <<< 16) - 33'(bias);
    hi_r <= (58'($signed(diff_r[32:16])) * $signed({1'b0, gain})) <<< 16;
    lo_r <= 58'($signed({1'b0, diff_r[15:0]})) * $signed({1'b0, gain});
    g_r <= 35'(prev) + 35'((prod + 58'sd8388608) >>> 24);
    blend_r <= 59'(g_r) * $signed({1'b0, WEIGHT_ONE - w}) + 59'(acc) * $signed({1'b0, w});
  end

  always_comb begin
    done = v_r[3];
    if (rv > 43'(ANGLE_LIMIT)) angle = ANGLE_LIMIT;
    else if (rv < -43'(ANGLE_LIMIT)) angle = -ANGLE_LIMIT;
    else angle = rv[24:0];
  end
endmodule
`default_nettype wire
